FILE: src/fpq_pkg.sv
// Package with mode codes and conversion functions for the precision quantizer.
package fpq_pkg;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_FP16 = 2'd1,
    MODE_BF16 = 2'd2,
    MODE_GRID = 2'd3
  } mode_t;

  localparam logic [31:0] EXP_MASK = 32'h7f80_0000;
  localparam logic [31:0] FRAC_MASK = 32'h007f_ffff;

  function automatic logic [4:0] msb_pos(input logic [23:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [31:0] via_fp16(input logic [31:0] bits);
    logic [15:0] sign;
    logic signed [9:0] hexp;
    logic [23:0] frac;
    logic [23:0] sig;
    logic [4:0] sh;
    logic [23:0] r;
    logic [15:0] half;
    logic [31:0] hsign;
    logic [4:0] he;
    logic [9:0] hm;
    logic [4:0] p;
    logic [31:0] res;
    sign = {bits[31], 15'd0};
    hexp = $signed({2'b00, bits[30:23]}) - 10'sd112;
    frac = {1'b0, bits[22:0]};
    half = 16'd0;
    if (hexp <= 10'sd0) begin
      if (hexp < -10'sd10) begin
        half = sign;
      end else begin
        sig = frac | 24'h80_0000;
        sh = 5'(10'sd14 - hexp);
        r = sig >> sh;
        if (sig[sh - 5'd1]) begin
          r = r + 24'd1;
        end
        half = sign | {5'd0, r[10:0]};
      end
    end else if (hexp >= 10'sd31) begin
      half = sign | 16'h7c00;
    end else begin
      frac = frac + 24'h1000;
      if (frac[23]) begin
        frac = 24'd0;
        hexp = hexp + 10'sd1;
      end
      if (hexp >= 10'sd31) begin
        half = sign | 16'h7c00;
      end else begin
        half = sign | {1'b0, hexp[4:0], frac[22:13]};
      end
    end
    hsign = {half[15], 31'd0};
    he = half[14:10];
    hm = half[9:0];
    if (he == 5'd0) begin
      if (hm == 10'd0) begin
        res = hsign;
      end else begin
        p = msb_pos({14'd0, hm});
        res = hsign | {1'b0, 8'(p) + 8'd103, 23'd0}
              | ({9'd0, 13'd0, hm} << (5'd23 - p) & FRAC_MASK);
      end
    end else if (he == 5'h1f) begin
      res = hsign | EXP_MASK | {9'd0, hm, 13'd0};
    end else begin
      res = hsign | {1'b0, 8'(he) + 8'd112, hm, 13'd0};
    end
    return res;
  endfunction

  function automatic logic [31:0] via_bf16(input logic [31:0] bits);
    logic [31:0] s;
    s = bits + 32'h7fff + {31'd0, bits[16]};
    return s & 32'hffff_0000;
  endfunction

  function automatic logic [31:0] via_grid(input logic [31:0] bits);
    logic [31:0] sign;
    logic [7:0] e;
    logic [7:0] sh;
    logic [24:0] sig;
    logic [24:0] r;
    logic [4:0] p;
    logic [31:0] res;
    sign = {bits[31], 31'd0};
    e = bits[30:23];
    res = sign;
    if ({1'b0, e} + 9'd10 >= 9'd255) begin
      res = sign | EXP_MASK;
    end else if (e >= 8'd140) begin
      res = bits;
    end else if (e != 8'd0) begin
      sh = 8'd140 - e;
      if (sh <= 8'd24) begin
        sig = {2'b01, bits[22:0]};
        r = (sig + (25'd1 << (sh - 8'd1))) >> sh;
        if (r != 25'd0) begin
          p = msb_pos(r[23:0]);
          res = sign | {1'b0, 8'(p) + 8'd117, 23'd0}
                | ({7'd0, r} << (5'd23 - p) & FRAC_MASK);
        end
      end
    end
    return res;
  endfunction

endpackage

FILE: src/fpq_core.sv
// Combinational precision reduction of one single-precision word.
module fpq_core
  import fpq_pkg::*;
(
  input  mode_t       mode,
  input  logic [31:0] value_bits,
  output logic [31:0] quantized_bits
);

  always_comb begin
    quantized_bits = value_bits;
    if ((value_bits & EXP_MASK) != EXP_MASK) begin
      unique case (mode)
        MODE_FP16: quantized_bits = via_fp16(value_bits);
        MODE_BF16: quantized_bits = via_bf16(value_bits);
        MODE_GRID: quantized_bits = via_grid(value_bits);
        default:   quantized_bits = value_bits;
      endcase
    end
  end

endmodule

FILE: src/float_precision_quantizer_unit.sv
// Path: an accepted word passes through the input register and then the result register before it is offered.
// Throughput: one word per cycle while out_stall is low; the input register refills whenever the result moves on.
// A stalled result holds while the input register keeps one more word.
// Reset (synchronous, active low) clears both valid flags and sets the mode to pass-through.
// Top level of the precision quantizer.
module float_precision_quantizer_unit
  import fpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_precision_mode,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_quantized_bits
);

  mode_t       mode_r;
  logic        a_vld_r;
  logic [31:0] a_bits_r;
  logic        o_vld_r;
  logic [31:0] o_bits_r;
  logic [31:0] q;
  logic        o_adv;

  fpq_core u_core (
    .mode          (mode_r),
    .value_bits    (a_bits_r),
    .quantized_bits(q)
  );

  assign o_adv = !o_vld_r || !out_stall;
  assign in_stall = a_vld_r && !o_adv;
  assign out_valid = o_vld_r;
  assign out_quantized_bits = o_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PASS;
      a_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= mode_t'(cfg_precision_mode);
      end
      if (o_adv) begin
        o_vld_r <= a_vld_r;
        if (a_vld_r) begin
          o_bits_r <= q;
        end
      end
      if (!in_stall) begin
        a_vld_r <= in_valid;
        if (in_valid) begin
          a_bits_r <= in_value_bits;
        end
      end
    end
  end

endmodule

FILE: src/fpq_checker.sv
// Port-level assertions for the precision quantizer and their bind.
module fpq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_quantized_bits
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_quantized_bits))
    else $error("stalled result changed");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("transfer did not reach the output");

  a_nostall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind float_precision_quantizer_unit fpq_checker u_fpq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_quantized_bits(out_quantized_bits)
);

FILE: tb/testbench.sv
// Self-checking testbench for the precision quantizer: directed table, then random words per mode.
`timescale 1ns / 1ps

module testbench;
  import fpq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS = 1950;
  localparam int DIRECTED_ROWS = 22;

  typedef struct {
    mode_t       mode;
    logic [31:0] word;
    logic        has_literal;
    logic [31:0] literal;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_precision_mode;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_value_bits;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_quantized_bits;

  logic [31:0] expected_words[$];
  mode_t       active_mode;
  int          error_count;
  int          cycle_count;
  bit          quiet_phase;
  stim_row_t   directed[DIRECTED_ROWS];

  float_precision_quantizer_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_precision_mode(cfg_precision_mode),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_value_bits(in_value_bits),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_quantized_bits(out_quantized_bits)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [4:0] top_bit(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [31:0] round_trip_half(input logic [31:0] bits);
    logic [15:0] half;
    int          hexp;
    logic [31:0] frac;
    logic [31:0] sig;
    logic [31:0] r;
    int          sh;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [4:0]  p;
    half = {bits[31], 15'd0};
    hexp = int'(bits[30:23]) - 112;
    frac = {9'd0, bits[22:0]};
    if (hexp <= 0) begin
      if (hexp >= -10) begin
        sig = frac | 32'h0080_0000;
        sh = 14 - hexp;
        r = sig >> sh;
        if (sig[sh - 1]) begin
          r = r + 1;
        end
        half = half | 16'(r & 32'h7ff);
      end
    end else if (hexp >= 31) begin
      half = half | 16'h7c00;
    end else begin
      frac = frac + 32'h1000;
      if (frac[23]) begin
        frac = 0;
        hexp = hexp + 1;
      end
      if (hexp >= 31) begin
        half = half | 16'h7c00;
      end else begin
        half = half | 16'(hexp << 10) | 16'((frac >> 13) & 32'h3ff);
      end
    end
    he = half[14:10];
    hm = half[9:0];
    if (he == 5'd0) begin
      if (hm == 10'd0) begin
        return {half[15], 31'd0};
      end
      p = top_bit({22'd0, hm});
      return {half[15], 8'(p + 103), 23'((32'(hm) << (23 - p)) & 32'h7f_ffff)};
    end
    if (he == 5'h1f) begin
      return {half[15], 8'hff, hm, 13'd0};
    end
    return {half[15], 8'(he + 112), hm, 13'd0};
  endfunction

  function automatic logic [31:0] snap_to_grid(input logic [31:0] bits);
    logic [31:0] sign;
    int          e;
    int          sh;
    logic [63:0] r;
    logic [4:0]  p;
    sign = {bits[31], 31'd0};
    e = int'(bits[30:23]);
    if (e + 10 >= 255) begin
      return sign | 32'h7f80_0000;
    end
    if (e >= 140) begin
      return bits;
    end
    if (e == 0 || 140 - e > 24) begin
      return sign;
    end
    sh = 140 - e;
    r = (64'({1'b1, bits[22:0]}) + (64'd1 << (sh - 1))) >> sh;
    if (r == 0) begin
      return sign;
    end
    p = top_bit(r[31:0]);
    return sign | {1'b0, 8'(p + 117), 23'((r[31:0] << (23 - p)) & 32'h7f_ffff)};
  endfunction

  function automatic logic [31:0] quantize(input mode_t mode, input logic [31:0] bits);
    if (bits[30:23] == 8'hff) begin
      return bits;
    end
    case (mode)
      MODE_FP16: return round_trip_half(bits);
      MODE_BF16: return (bits + 32'h7fff + 32'(bits[16])) & 32'hffff_0000;
      MODE_GRID: return snap_to_grid(bits);
      default: return bits;
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_quantized_bits);
        error_count <= error_count + 1;
      end else begin
        want = expected_words.pop_front();
        if (want !== out_quantized_bits) begin
          $display("%0t: quantized_bits expected %h actual %h", $time, want,
                   out_quantized_bits);
          error_count <= error_count + 1;
        end
      end
    end
  end

  initial begin
    int idle;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet_phase) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        idle = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (idle) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic set_mode(input mode_t mode);
    cfg_we <= 1'b1;
    cfg_precision_mode <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_mode = mode;
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_word(input logic [31:0] word, input logic [31:0] want);
    int idle;
    if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      idle = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value_bits <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(want);
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: w[30:23] = 8'(112 + $urandom_range(0, 1) - $urandom_range(0, 12));
      1: w[30:23] = 8'($urandom_range(125, 145));
      2: w[30:23] = 8'($urandom_range(250, 255));
      3: w[22:0] = $urandom_range(0, 1) ? 23'h7f_ffff : 23'(w[22:0] & 23'h7f_e000);
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    directed[0] = '{MODE_PASS, 32'h3f80_0001, 1'b1, 32'h3f80_0001};
    directed[1] = '{MODE_PASS, 32'hffff_ffff, 1'b1, 32'hffff_ffff};
    directed[2] = '{MODE_PASS, 32'h0000_0000, 1'b1, 32'h0000_0000};
    directed[3] = '{MODE_FP16, 32'h7fc0_1234, 1'b1, 32'h7fc0_1234};
    directed[4] = '{MODE_FP16, 32'hff80_0000, 1'b1, 32'hff80_0000};
    directed[5] = '{MODE_FP16, 32'h0000_0001, 1'b1, 32'h0000_0000};
    directed[6] = '{MODE_FP16, 32'h8000_0001, 1'b1, 32'h8000_0000};
    directed[7] = '{MODE_FP16, 32'h7f7f_ffff, 1'b1, 32'h7f80_0000};
    directed[8] = '{MODE_FP16, 32'h477f_f000, 1'b1, 32'h7f80_0000};
    directed[9] = '{MODE_FP16, 32'h3f80_0000, 1'b1, 32'h3f80_0000};
    directed[10] = '{MODE_FP16, 32'h387f_f000, 1'b0, 0};
    directed[11] = '{MODE_FP16, 32'h3380_0000, 1'b0, 0};
    directed[12] = '{MODE_FP16, 32'h3f80_1000, 1'b0, 0};
    directed[13] = '{MODE_BF16, 32'h3f80_8000, 1'b1, 32'h3f80_0000};
    directed[14] = '{MODE_BF16, 32'h3f81_8000, 1'b1, 32'h3f82_0000};
    directed[15] = '{MODE_BF16, 32'h7f7f_ffff, 1'b1, 32'h7f80_0000};
    directed[16] = '{MODE_BF16, 32'h7f80_0001, 1'b1, 32'h7f80_0001};
    directed[17] = '{MODE_GRID, 32'h3a00_0000, 1'b1, 32'h3a80_0000};
    directed[18] = '{MODE_GRID, 32'hb9ff_ffff, 1'b1, 32'h8000_0000};
    directed[19] = '{MODE_GRID, 32'h7f7f_ffff, 1'b1, 32'h7f80_0000};
    directed[20] = '{MODE_GRID, 32'h0000_0001, 1'b1, 32'h0000_0000};
    directed[21] = '{MODE_GRID, 32'h3f80_0123, 1'b0, 0};

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_precision_mode = MODE_PASS;
    in_valid = 1'b0;
    in_value_bits = 32'd0;
    error_count = 0;
    cycle_count = 0;
    quiet_phase = 1'b0;
    active_mode = MODE_PASS;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(32'h4049_0fdb, 32'h4049_0fdb);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed[i].mode != active_mode) begin
        in_valid <= 1'b0;
        drain();
        set_mode(directed[i].mode);
      end
      send_word(directed[i].word, directed[i].has_literal ? directed[i].literal
                                  : quantize(active_mode, directed[i].word));
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      logic [31:0] w;
      if (i % 150 == 0) begin
        in_valid <= 1'b0;
        drain();
        set_mode(mode_t'($urandom_range(0, 3)));
      end
      if (i >= RAND_ITEMS - 200) begin
        quiet_phase = 1'b1;
      end
      w = random_word();
      send_word(w, quantize(active_mode, w));
    end
    in_valid <= 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
